@@ design/obd2rd_pkg.sv @@
// obd2rd_pkg: codes, constants and scaling helpers of the obd-ii response decoder
// used by obd2_response_decoder_core; depends on nothing else
`timescale 1ns / 1ps

package obd2rd_pkg;

   // request kinds
   typedef enum logic [1:0] {
      ACT_FRAME = 2'd0,
      ACT_TICK  = 2'd1,
      ACT_READ  = 2'd2
   } action_type;

   // reported quantity codes, also used as read selects
   localparam logic [4:0] QTY_NONE      = 5'd0;
   localparam logic [4:0] QTY_RPM       = 5'd1;
   localparam logic [4:0] QTY_SPEED     = 5'd2;
   localparam logic [4:0] QTY_COOLANT   = 5'd3;
   localparam logic [4:0] QTY_LOAD      = 5'd4;
   localparam logic [4:0] QTY_OIL       = 5'd5;
   localparam logic [4:0] QTY_MAF       = 5'd6;
   localparam logic [4:0] QTY_THROTTLE  = 5'd7;
   localparam logic [4:0] QTY_FUEL      = 5'd8;
   localparam logic [4:0] QTY_BATTERY   = 5'd9;
   localparam logic [4:0] QTY_FAULT_CNT = 5'd10;
   localparam logic [4:0] QTY_DTC_BASE  = 5'd11;

   // response identifiers and services
   localparam logic [10:0] FRAME_ID_LOW  = 11'h7E8;
   localparam logic [10:0] FRAME_ID_HIGH = 11'h7EF;
   localparam logic [3:0]  FRAME_LEN_MIN = 4'd4;
   localparam logic [7:0]  SVC_CURRENT   = 8'h41;
   localparam logic [7:0]  SVC_DTC       = 8'h43;

   // service 01 pids
   localparam logic [7:0] PID_RPM      = 8'h0C;
   localparam logic [7:0] PID_SPEED    = 8'h0D;
   localparam logic [7:0] PID_COOLANT  = 8'h05;
   localparam logic [7:0] PID_LOAD     = 8'h04;
   localparam logic [7:0] PID_OIL      = 8'h5C;
   localparam logic [7:0] PID_MAF      = 8'h10;
   localparam logic [7:0] PID_TPS      = 8'h11;
   localparam logic [7:0] PID_FUEL     = 8'h2F;
   localparam logic [7:0] PID_BATTERY  = 8'h42;

   localparam logic [15:0] AGE_STALE      = 16'hFFFF;
   localparam logic [15:0] WINDOW_RESET   = 16'd1000;
   localparam int          DTC_MAX        = 8;

   // a * 100 / 255 without a divider: x / 255 == (x + (x >> 8) + 1) >> 8 for x <= 25500
   function automatic logic [6:0] pct_of(input logic [7:0] a);
      logic [14:0] x;
      logic [15:0] sum;
      x   = 15'(a) * 15'd100;
      sum = 16'(x) + 16'(x >> 8) + 16'd1;
      return 7'(sum >> 8);
   endfunction

endpackage

@@ design/obd2_response_decoder_core.sv @@
// obd2_response_decoder_core: decodes service 01 / 03 replies, keeps quantities and age
// depends on obd2rd_pkg
`timescale 1ns / 1ps

// the response beat is registered: it is presented in the cycle after its request beat is accepted
// throughput: one beat per cycle; the single response register is refilled in the
//   same cycle it is drained, so req_ready only drops while a response is held
// reset: synchronous, active high; quantities and dtc data clear to zero, the age
//   counter starts saturated (stale) and the freshness window returns to 1000 ms
module obd2_response_decoder_core #(
   parameter int DtcMax = obd2rd_pkg::DTC_MAX
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic [10:0]        req_frame_id,
   input  logic [3:0]         req_frame_length,
   input  logic [7:0]         req_byte_pci,
   input  logic [7:0]         req_byte_service,
   input  logic [7:0]         req_byte_two,
   input  logic [7:0]         req_byte_three,
   input  logic [7:0]         req_byte_four,
   input  logic [7:0]         req_byte_five,
   input  logic [7:0]         req_byte_six,
   input  logic [7:0]         req_byte_seven,
   input  logic [4:0]         req_read_select,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [4:0]         rsp_quantity,
   output logic signed [16:0] rsp_value,
   output logic               rsp_fresh,

   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [15:0]        csr_fresh_window_ms
);

   localparam int CntW     = $clog2(DtcMax + 1);
   // only the first two codes fit in one frame and are stored; reads of higher entries return zero
   localparam int NumCodes = (DtcMax < 2) ? DtcMax : 2;

   logic [15:0]        window_ff;
   logic [13:0]        rpm_ff, rpm_in;
   logic [7:0]         speed_ff, speed_in;
   logic signed [8:0]  coolant_ff, coolant_in;
   logic [6:0]         load_ff, load_in;
   logic signed [8:0]  oil_ff, oil_in;
   logic [15:0]        maf_ff, maf_in;
   logic [6:0]         throttle_ff, throttle_in;
   logic [6:0]         fuel_ff, fuel_in;
   logic [15:0]        battery_ff, battery_in;
   logic [CntW-1:0]    fault_count_ff, fault_count_in;
   logic [15:0]        fault_codes_ff [NumCodes];
   logic [15:0]        fault_codes_in [NumCodes];
   logic [15:0]        age_ff, age_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [4:0]         rsp_quantity_ff, rsp_quantity_in;
   logic signed [16:0] rsp_value_ff, rsp_value_in;
   logic               rsp_fresh_ff, rsp_fresh_in;

   logic               accept;
   logic               frame_ok;
   logic [CntW-1:0]    fault_num;
   logic [4:0]         code_index;
   logic [15:0]        code_pair;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign frame_ok = (req_frame_id >= obd2rd_pkg::FRAME_ID_LOW)
                  && (req_frame_id <= obd2rd_pkg::FRAME_ID_HIGH)
                  && (req_frame_length >= obd2rd_pkg::FRAME_LEN_MIN);

   // dtc count clamped to DtcMax
   assign fault_num = (req_byte_two > 8'(DtcMax)) ? CntW'(DtcMax) : CntW'(req_byte_two);
   assign code_index = req_read_select - obd2rd_pkg::QTY_DTC_BASE;

   always_comb begin
      rpm_in          = rpm_ff;
      speed_in        = speed_ff;
      coolant_in      = coolant_ff;
      load_in         = load_ff;
      oil_in          = oil_ff;
      maf_in          = maf_ff;
      throttle_in     = throttle_ff;
      fuel_in         = fuel_ff;
      battery_in      = battery_ff;
      fault_count_in  = fault_count_ff;
      fault_codes_in  = fault_codes_ff;
      age_in          = age_ff;
      rsp_quantity_in = obd2rd_pkg::QTY_NONE;
      rsp_value_in    = '0;
      code_pair       = '0;

      if (accept) begin
         unique case (obd2rd_pkg::action_type'(req_action))
            obd2rd_pkg::ACT_FRAME: begin
               if (frame_ok && req_byte_service == obd2rd_pkg::SVC_DTC) begin
                  fault_count_in = fault_num;
                  for (int i = 0; i < NumCodes; i++) begin
                     code_pair = (i == 0) ? {req_byte_three, req_byte_four}
                                          : {req_byte_five, req_byte_six};
                     if (CntW'(i) < fault_num) begin
                        fault_codes_in[i] = code_pair;
                     end
                  end
                  age_in          = '0;
                  rsp_quantity_in = obd2rd_pkg::QTY_FAULT_CNT;
                  rsp_value_in    = 17'(fault_num);
               end else if (frame_ok && req_byte_service == obd2rd_pkg::SVC_CURRENT) begin
                  unique case (req_byte_two)
                     obd2rd_pkg::PID_RPM: begin
                        rpm_in          = 14'({req_byte_three, req_byte_four} >> 2);
                        rsp_quantity_in = obd2rd_pkg::QTY_RPM;
                        rsp_value_in    = 17'(rpm_in);
                     end
                     obd2rd_pkg::PID_SPEED: begin
                        speed_in        = req_byte_three;
                        rsp_quantity_in = obd2rd_pkg::QTY_SPEED;
                        rsp_value_in    = 17'(req_byte_three);
                     end
                     obd2rd_pkg::PID_COOLANT: begin
                        coolant_in      = $signed({1'b0, req_byte_three}) - 9'sd40;
                        rsp_quantity_in = obd2rd_pkg::QTY_COOLANT;
                        rsp_value_in    = 17'(coolant_in);
                     end
                     obd2rd_pkg::PID_LOAD: begin
                        load_in         = obd2rd_pkg::pct_of(req_byte_three);
                        rsp_quantity_in = obd2rd_pkg::QTY_LOAD;
                        rsp_value_in    = 17'(load_in);
                     end
                     obd2rd_pkg::PID_OIL: begin
                        oil_in          = $signed({1'b0, req_byte_three}) - 9'sd40;
                        rsp_quantity_in = obd2rd_pkg::QTY_OIL;
                        rsp_value_in    = 17'(oil_in);
                     end
                     obd2rd_pkg::PID_MAF: begin
                        maf_in          = {req_byte_three, req_byte_four};
                        rsp_quantity_in = obd2rd_pkg::QTY_MAF;
                        rsp_value_in    = 17'(maf_in);
                     end
                     obd2rd_pkg::PID_TPS: begin
                        throttle_in     = obd2rd_pkg::pct_of(req_byte_three);
                        rsp_quantity_in = obd2rd_pkg::QTY_THROTTLE;
                        rsp_value_in    = 17'(throttle_in);
                     end
                     obd2rd_pkg::PID_FUEL: begin
                        fuel_in         = obd2rd_pkg::pct_of(req_byte_three);
                        rsp_quantity_in = obd2rd_pkg::QTY_FUEL;
                        rsp_value_in    = 17'(fuel_in);
                     end
                     obd2rd_pkg::PID_BATTERY: begin
                        battery_in      = {req_byte_three, req_byte_four};
                        rsp_quantity_in = obd2rd_pkg::QTY_BATTERY;
                        rsp_value_in    = 17'(battery_in);
                     end
                     default: ;
                  endcase
                  if (rsp_quantity_in != obd2rd_pkg::QTY_NONE) begin
                     age_in = '0;
                  end
               end
            end
            obd2rd_pkg::ACT_TICK: begin
               if (age_ff != obd2rd_pkg::AGE_STALE) begin
                  age_in = age_ff + 16'd1;
               end
            end
            obd2rd_pkg::ACT_READ: begin
               rsp_quantity_in = req_read_select;
               unique case (req_read_select)
                  obd2rd_pkg::QTY_RPM:       rsp_value_in = 17'(rpm_ff);
                  obd2rd_pkg::QTY_SPEED:     rsp_value_in = 17'(speed_ff);
                  obd2rd_pkg::QTY_COOLANT:   rsp_value_in = 17'(coolant_ff);
                  obd2rd_pkg::QTY_LOAD:      rsp_value_in = 17'(load_ff);
                  obd2rd_pkg::QTY_OIL:       rsp_value_in = 17'(oil_ff);
                  obd2rd_pkg::QTY_MAF:       rsp_value_in = 17'(maf_ff);
                  obd2rd_pkg::QTY_THROTTLE:  rsp_value_in = 17'(throttle_ff);
                  obd2rd_pkg::QTY_FUEL:      rsp_value_in = 17'(fuel_ff);
                  obd2rd_pkg::QTY_BATTERY:   rsp_value_in = 17'(battery_ff);
                  obd2rd_pkg::QTY_FAULT_CNT: rsp_value_in = 17'(fault_count_ff);
                  default: begin
                     // dtc code reads; anything outside the stored count reads as none
                     if (req_read_select >= obd2rd_pkg::QTY_DTC_BASE
                         && 6'(code_index) < 6'(fault_count_ff)) begin
                        for (int i = 0; i < NumCodes; i++) begin
                           if (code_index == 5'(i)) begin
                              rsp_value_in = 17'(fault_codes_ff[i]);
                           end
                        end
                     end else begin
                        rsp_quantity_in = obd2rd_pkg::QTY_NONE;
                     end
                  end
               endcase
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      // freshness is judged on the age left by this beat
      rsp_fresh_in = (age_in < window_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff      <= obd2rd_pkg::WINDOW_RESET;
         rpm_ff         <= '0;
         speed_ff       <= '0;
         coolant_ff     <= '0;
         load_ff        <= '0;
         oil_ff         <= '0;
         maf_ff         <= '0;
         throttle_ff    <= '0;
         fuel_ff        <= '0;
         battery_ff     <= '0;
         fault_count_ff <= '0;
         for (int i = 0; i < NumCodes; i++) begin
            fault_codes_ff[i] <= '0;
         end
         age_ff         <= obd2rd_pkg::AGE_STALE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            window_ff <= csr_fresh_window_ms;
         end
         rpm_ff         <= rpm_in;
         speed_ff       <= speed_in;
         coolant_ff     <= coolant_in;
         load_ff        <= load_in;
         oil_ff         <= oil_in;
         maf_ff         <= maf_in;
         throttle_ff    <= throttle_in;
         fuel_ff        <= fuel_in;
         battery_ff     <= battery_in;
         fault_count_ff <= fault_count_in;
         fault_codes_ff <= fault_codes_in;
         age_ff         <= age_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // response payload, loaded only on an accepted beat
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_quantity_ff <= rsp_quantity_in;
         rsp_value_ff    <= rsp_value_in;
         rsp_fresh_ff    <= rsp_fresh_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_quantity = rsp_quantity_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_fresh    = rsp_fresh_ff;

endmodule
